/* hw/rtl/tree_segment_morphology_accumulator_top_defines.svh */
// Assertion macros shared by the tree morphology accumulator RTL.
// Included by the controller and datapath; no other dependencies.
`ifndef TREE_SEGMENT_MORPHOLOGY_ACCUMULATOR_TOP_DEFINES_SVH
`define TREE_SEGMENT_MORPHOLOGY_ACCUMULATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSMA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tsma: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TSMA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tsma: next-cycle check failed");

`endif

/* hw/rtl/tsma_pkg.sv */
// Types and constants shared by the tree morphology accumulator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tsma_pkg;

    localparam int COORD_W  = 20;
    localparam int RAD_W    = 16;
    localparam int DIAM_W   = 17;
    localparam int SEG_W    = 21;
    localparam int TLEN_W   = 37;
    localparam int SUM_W    = 56;
    localparam int DSUM_W   = 34;
    localparam int NODES_W  = 17;
    localparam int RADIC_W  = 42;
    localparam int SREM_W   = 22;
    localparam int CFG_W    = 2;
    localparam int CNT_W    = 6;

    localparam logic [NODES_W-1:0] MAX_NODES = 17'd65536;
    // pi in Q.24
    localparam logic [25:0] PI_Q24 = 26'd52707179;

    localparam int AXES       = 3;
    localparam int SQRT_STEPS = 21;
    localparam int MUL_STEPS  = 7;
    localparam int DIV_STEPS  = 34;

    typedef logic [CNT_W-1:0] t_cnt;

    localparam t_cnt SQ_LAST   = t_cnt'(AXES - 1);
    localparam t_cnt SQRT_LAST = t_cnt'(SQRT_STEPS - 1);
    localparam t_cnt MUL_LAST  = t_cnt'(MUL_STEPS - 1);
    localparam t_cnt DIV_LAST  = t_cnt'(DIV_STEPS - 1);

    localparam logic [CFG_W-1:0] CFG_ROOT_X = 2'd0;
    localparam logic [CFG_W-1:0] CFG_ROOT_Y = 2'd1;
    localparam logic [CFG_W-1:0] CFG_ROOT_Z = 2'd2;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // multiplier schedule
    localparam logic [2:0] MUL_RL = 3'd0;
    localparam logic [2:0] MUL_RR = 3'd1;
    localparam logic [2:0] MUL_Q  = 3'd2;
    localparam logic [2:0] MUL_SH = 3'd3;
    localparam logic [2:0] MUL_SL = 3'd4;
    localparam logic [2:0] MUL_VH = 3'd5;
    localparam logic [2:0] MUL_VL = 3'd6;

    typedef enum logic [3:0] {
        OP_NONE     = 4'd0,
        OP_LOAD     = 4'd1,
        OP_SQ       = 4'd2,
        OP_SQRT     = 4'd3,
        OP_MUL      = 4'd4,
        OP_ACC      = 4'd5,
        OP_DIV_INIT = 4'd6,
        OP_DIV      = 4'd7,
        OP_EMIT     = 4'd8
    } t_op;

    typedef struct packed {
        t_op  op;
        t_cnt idx;
        logic root_sel;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic has_parent;
        logic last;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

/* hw/rtl/tsma_ctrl.sv */
// Sequencer for the tree morphology accumulator: steps the datapath through
// squares, root extraction, products, accumulation and division. Uses tsma_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "tree_segment_morphology_accumulator_top_defines.svh"

module tsma_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire tsma_pkg::t_status i_status,
    output tsma_pkg::t_cmd        o_cmd
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_DISP  = 9'b000000010,
        ST_SQ    = 9'b000000100,
        ST_ROOT  = 9'b000001000,
        ST_MUL   = 9'b000010000,
        ST_ACC   = 9'b000100000,
        ST_DINIT = 9'b001000000,
        ST_DIV   = 9'b010000000,
        ST_EMIT  = 9'b100000000
    } t_state;

    t_state         r_state, n_state;
    tsma_pkg::t_cnt r_cnt, n_cnt;
    logic           r_pass, n_pass;

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_pass       = r_pass;
        o_cmd.op       = tsma_pkg::OP_NONE;
        o_cmd.idx      = r_cnt;
        o_cmd.root_sel = r_pass;
        o_cmd.fin      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = tsma_pkg::OP_LOAD;
                    n_state  = ST_DISP;
                end
            end
            ST_DISP: begin
                n_cnt  = '0;
                n_pass = 1'b0;
                if (i_status.has_parent) begin
                    n_state = ST_SQ;
                end else if (i_status.last) begin
                    n_state = ST_DINIT;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SQ: begin
                o_cmd.op = tsma_pkg::OP_SQ;
                if (r_cnt == tsma_pkg::SQ_LAST) begin
                    n_cnt   = '0;
                    n_state = ST_ROOT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_ROOT: begin
                o_cmd.op  = tsma_pkg::OP_SQRT;
                o_cmd.fin = (r_cnt == tsma_pkg::SQRT_LAST);
                if (r_cnt == tsma_pkg::SQRT_LAST) begin
                    n_cnt = '0;
                    // first pass measures the segment, second the root distance
                    if (r_pass) begin
                        n_state = ST_MUL;
                    end else begin
                        n_pass  = 1'b1;
                        n_state = ST_SQ;
                    end
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_MUL: begin
                o_cmd.op = tsma_pkg::OP_MUL;
                if (r_cnt == tsma_pkg::MUL_LAST) begin
                    n_cnt   = '0;
                    n_state = ST_ACC;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_ACC: begin
                o_cmd.op = tsma_pkg::OP_ACC;
                n_state  = i_status.last ? ST_DINIT : ST_IDLE;
            end
            ST_DINIT: begin
                o_cmd.op = tsma_pkg::OP_DIV_INIT;
                n_cnt    = '0;
                n_state  = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.op = tsma_pkg::OP_DIV;
                if (r_cnt == tsma_pkg::DIV_LAST) begin
                    n_cnt   = '0;
                    n_state = ST_EMIT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_EMIT: begin
                // hold until the output register is free
                if (i_status.out_free) begin
                    o_cmd.op = tsma_pkg::OP_EMIT;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // no transfer while reset is held
    assign o_in_stall = !i_rst_n || (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_pass  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pass  <= n_pass;
        end
    end

    `TSMA_ASSERT_IMPL(a_sqrt_cnt_bound, i_clk, i_rst_n, r_state == ST_ROOT, r_cnt <= tsma_pkg::SQRT_LAST)
    `TSMA_ASSERT_IMPL(a_emit_after_div, i_clk, i_rst_n, r_state == ST_EMIT, ($past(r_state) == ST_DIV) || ($past(r_state) == ST_EMIT))
    `TSMA_ASSERT_NEXT(a_div_starts_clean, i_clk, i_rst_n, r_state == ST_DINIT, (r_state == ST_DIV) && (r_cnt == '0))

endmodule

`default_nettype wire

/* hw/rtl/tsma_dpath.sv */
// Datapath for the tree morphology accumulator: shared multiplier, digit
// recurrence square root, restoring divider and running sums. Uses tsma_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "tree_segment_morphology_accumulator_top_defines.svh"

module tsma_dpath (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [tsma_pkg::CFG_W-1:0]            i_cfg_addr,
    input  wire logic [tsma_pkg::COORD_W-1:0]          i_cfg_data,
    input  wire logic [tsma_pkg::COORD_W-1:0]          i_node_x,
    input  wire logic [tsma_pkg::COORD_W-1:0]          i_node_y,
    input  wire logic [tsma_pkg::COORD_W-1:0]          i_node_z,
    input  wire logic [tsma_pkg::RAD_W-1:0]            i_node_radius,
    input  wire logic                                  i_has_parent,
    input  wire logic [tsma_pkg::COORD_W-1:0]          i_parent_x,
    input  wire logic [tsma_pkg::COORD_W-1:0]          i_parent_y,
    input  wire logic [tsma_pkg::COORD_W-1:0]          i_parent_z,
    input  wire logic                                  i_last_node,
    input  wire tsma_pkg::t_cmd                        i_cmd,
    output tsma_pkg::t_status                          o_status,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output logic [tsma_pkg::COORD_W-1:0]               o_width,
    output logic [tsma_pkg::COORD_W-1:0]               o_height,
    output logic [tsma_pkg::COORD_W-1:0]               o_depth_extent,
    output logic [tsma_pkg::DIAM_W-1:0]                o_average_diameter,
    output logic [tsma_pkg::TLEN_W-1:0]                o_total_length,
    output logic [tsma_pkg::SUM_W-1:0]                 o_total_surface,
    output logic [tsma_pkg::SUM_W-1:0]                 o_total_volume,
    output logic [tsma_pkg::SEG_W-1:0]                 o_max_root_distance,
    output logic [tsma_pkg::NODES_W-1:0]               o_node_count
);

    localparam int CW = tsma_pkg::COORD_W;

    // configuration
    logic [CW-1:0] r_root_x, r_root_y, r_root_z;

    // captured item
    logic [CW-1:0] r_x, r_y, r_z, r_px, r_py, r_pz;
    logic [tsma_pkg::RAD_W-1:0] r_r;
    logic r_hp, r_last;

    // tree state
    logic [CW-1:0] r_min_x, r_min_y, r_min_z, r_max_x, r_max_y, r_max_z;
    logic [tsma_pkg::DSUM_W-1:0]  r_dsum;
    logic [tsma_pkg::TLEN_W-1:0]  r_lsum;
    logic [tsma_pkg::SUM_W-1:0]   r_ssum, r_vsum;
    logic [tsma_pkg::SEG_W-1:0]   r_dmax;
    logic [tsma_pkg::NODES_W-1:0] r_nodes;

    // work registers
    logic [tsma_pkg::RADIC_W-1:0] r_rad;
    logic [tsma_pkg::SREM_W-1:0]  r_srem;
    logic [tsma_pkg::SEG_W-1:0]   r_sroot, r_len, r_rdist;
    logic [36:0] r_rl;
    logic [31:0] r_rr;
    logic [52:0] r_q;
    logic [38:0] r_sh;
    logic [49:0] r_sl;
    logic [54:0] r_vh;
    logic [49:0] r_vl;
    logic [tsma_pkg::DSUM_W-1:0]  r_dq;
    logic [tsma_pkg::NODES_W-1:0] r_drem;
    logic r_out_valid;

    // difference for the square step
    logic [CW-1:0] s_node_c, s_other_c, s_diff;
    always_comb begin
        unique case (i_cmd.idx[1:0])
            tsma_pkg::AXIS_X: begin
                s_node_c  = r_x;
                s_other_c = i_cmd.root_sel ? r_root_x : r_px;
            end
            tsma_pkg::AXIS_Y: begin
                s_node_c  = r_y;
                s_other_c = i_cmd.root_sel ? r_root_y : r_py;
            end
            tsma_pkg::AXIS_Z: begin
                s_node_c  = r_z;
                s_other_c = i_cmd.root_sel ? r_root_z : r_pz;
            end
            default: begin
                s_node_c  = '0;
                s_other_c = '0;
            end
        endcase
        s_diff = (s_node_c > s_other_c) ? (s_node_c - s_other_c) : (s_other_c - s_node_c);
    end

    // shared multiplier
    logic [31:0] s_mul_a, s_mul_b;
    logic [63:0] s_prod;
    always_comb begin
        s_mul_a = '0;
        s_mul_b = '0;
        if (i_cmd.op == tsma_pkg::OP_SQ) begin
            s_mul_a = 32'(s_diff);
            s_mul_b = 32'(s_diff);
        end else if (i_cmd.op == tsma_pkg::OP_MUL) begin
            unique case (i_cmd.idx[2:0])
                tsma_pkg::MUL_RL: begin
                    s_mul_a = 32'(r_r);
                    s_mul_b = 32'(r_len);
                end
                tsma_pkg::MUL_RR: begin
                    s_mul_a = 32'(r_r);
                    s_mul_b = 32'(r_r);
                end
                tsma_pkg::MUL_Q: begin
                    s_mul_a = r_rr;
                    s_mul_b = 32'(r_len);
                end
                tsma_pkg::MUL_SH: begin
                    s_mul_a = 32'(r_rl[36:24]);
                    s_mul_b = 32'(tsma_pkg::PI_Q24);
                end
                tsma_pkg::MUL_SL: begin
                    s_mul_a = 32'(r_rl[23:0]);
                    s_mul_b = 32'(tsma_pkg::PI_Q24);
                end
                tsma_pkg::MUL_VH: begin
                    s_mul_a = 32'(r_q[52:24]);
                    s_mul_b = 32'(tsma_pkg::PI_Q24);
                end
                tsma_pkg::MUL_VL: begin
                    s_mul_a = 32'(r_q[23:0]);
                    s_mul_b = 32'(tsma_pkg::PI_Q24);
                end
                default: begin
                    s_mul_a = '0;
                    s_mul_b = '0;
                end
            endcase
        end
    end
    assign s_prod = s_mul_a * s_mul_b;

    // one root bit per step
    logic [23:0] s_scur, s_stry, s_ssub;
    logic        s_sge;
    logic [tsma_pkg::SEG_W-1:0] s_sroot_n;
    assign s_scur    = {r_srem, r_rad[tsma_pkg::RADIC_W-1 -: 2]};
    assign s_stry    = {1'b0, r_sroot, 2'b01};
    assign s_sge     = (s_scur >= s_stry);
    assign s_ssub    = s_scur - s_stry;
    assign s_sroot_n = {r_sroot[tsma_pkg::SEG_W-2:0], s_sge};

    // one quotient bit per step
    logic [tsma_pkg::NODES_W:0] s_dt, s_dsub;
    logic s_dge;
    assign s_dt   = {r_drem, r_dq[tsma_pkg::DSUM_W-1]};
    assign s_dge  = (s_dt >= {1'b0, r_nodes});
    assign s_dsub = s_dt - {1'b0, r_nodes};

    // rounded surface and volume terms, then saturating sums
    logic [63:0] s_surf_full;
    logic [36:0] s_surf;
    logic [50:0] s_vb;
    logic [55:0] s_va;
    logic [47:0] s_vol;
    logic [tsma_pkg::DSUM_W:0] s_dsum;
    logic [tsma_pkg::TLEN_W:0] s_lsum;
    logic [tsma_pkg::SUM_W:0]  s_ssum, s_vsum;
    assign s_surf_full = {1'b0, r_sh, 24'd0} + 64'(r_sl) + (64'd1 << 26);
    assign s_surf      = s_surf_full[63:27];
    assign s_vb        = 51'(r_vl) + (51'd1 << 31);
    assign s_va        = 56'(r_vh) + 56'(s_vb[50:24]);
    assign s_vol       = s_va[55:8];
    assign s_dsum = {1'b0, r_dsum} + (tsma_pkg::DSUM_W + 1)'({r_r, 1'b0});
    assign s_lsum = {1'b0, r_lsum} + (tsma_pkg::TLEN_W + 1)'(r_len);
    assign s_ssum = {1'b0, r_ssum} + (tsma_pkg::SUM_W + 1)'(s_surf);
    assign s_vsum = {1'b0, r_vsum} + (tsma_pkg::SUM_W + 1)'(s_vol);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_x <= '0;
            r_root_y <= '0;
            r_root_z <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                tsma_pkg::CFG_ROOT_X: r_root_x <= i_cfg_data;
                tsma_pkg::CFG_ROOT_Y: r_root_y <= i_cfg_data;
                tsma_pkg::CFG_ROOT_Z: r_root_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // item capture and work registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            tsma_pkg::OP_LOAD: begin
                r_x    <= i_node_x;
                r_y    <= i_node_y;
                r_z    <= i_node_z;
                r_r    <= i_node_radius;
                r_hp   <= i_has_parent;
                r_px   <= i_parent_x;
                r_py   <= i_parent_y;
                r_pz   <= i_parent_z;
                r_last <= i_last_node;
            end
            tsma_pkg::OP_SQ: begin
                r_rad <= ((i_cmd.idx[1:0] == tsma_pkg::AXIS_X) ? '0 : r_rad)
                         + tsma_pkg::RADIC_W'(s_prod);
                if (i_cmd.idx[1:0] == tsma_pkg::AXIS_X) begin
                    r_srem  <= '0;
                    r_sroot <= '0;
                end
            end
            tsma_pkg::OP_SQRT: begin
                r_rad   <= {r_rad[tsma_pkg::RADIC_W-3:0], 2'b00};
                r_srem  <= s_sge ? s_ssub[tsma_pkg::SREM_W-1:0] : s_scur[tsma_pkg::SREM_W-1:0];
                r_sroot <= s_sroot_n;
                if (i_cmd.fin) begin
                    if (i_cmd.root_sel) begin
                        r_rdist <= s_sroot_n;
                    end else begin
                        r_len <= s_sroot_n;
                    end
                end
            end
            tsma_pkg::OP_MUL: begin
                unique case (i_cmd.idx[2:0])
                    tsma_pkg::MUL_RL: r_rl <= s_prod[36:0];
                    tsma_pkg::MUL_RR: r_rr <= s_prod[31:0];
                    tsma_pkg::MUL_Q:  r_q  <= s_prod[52:0];
                    tsma_pkg::MUL_SH: r_sh <= s_prod[38:0];
                    tsma_pkg::MUL_SL: r_sl <= s_prod[49:0];
                    tsma_pkg::MUL_VH: r_vh <= s_prod[54:0];
                    tsma_pkg::MUL_VL: r_vl <= s_prod[49:0];
                    default: ;
                endcase
            end
            tsma_pkg::OP_DIV_INIT: begin
                r_dq   <= r_dsum;
                r_drem <= '0;
            end
            tsma_pkg::OP_DIV: begin
                r_dq   <= {r_dq[tsma_pkg::DSUM_W-2:0], s_dge};
                r_drem <= s_dge ? s_dsub[tsma_pkg::NODES_W-1:0] : s_dt[tsma_pkg::NODES_W-1:0];
            end
            tsma_pkg::OP_EMIT: begin
                o_width             <= r_max_x - r_min_x;
                o_height            <= r_max_y - r_min_y;
                o_depth_extent      <= r_max_z - r_min_z;
                o_average_diameter  <= (|r_dq[tsma_pkg::DSUM_W-1:tsma_pkg::DIAM_W])
                                       ? '1 : r_dq[tsma_pkg::DIAM_W-1:0];
                o_total_length      <= r_lsum;
                o_total_surface     <= r_ssum;
                o_total_volume      <= r_vsum;
                o_max_root_distance <= r_dmax;
                o_node_count        <= r_nodes;
            end
            default: ;
        endcase
    end

    // tree state: box, count, sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x <= '1;
            r_min_y <= '1;
            r_min_z <= '1;
            r_max_x <= '0;
            r_max_y <= '0;
            r_max_z <= '0;
            r_dsum  <= '0;
            r_lsum  <= '0;
            r_ssum  <= '0;
            r_vsum  <= '0;
            r_dmax  <= '0;
            r_nodes <= '0;
        end else begin
            unique case (i_cmd.op)
                tsma_pkg::OP_LOAD: begin
                    if (i_node_x < r_min_x) r_min_x <= i_node_x;
                    if (i_node_y < r_min_y) r_min_y <= i_node_y;
                    if (i_node_z < r_min_z) r_min_z <= i_node_z;
                    if (i_node_x > r_max_x) r_max_x <= i_node_x;
                    if (i_node_y > r_max_y) r_max_y <= i_node_y;
                    if (i_node_z > r_max_z) r_max_z <= i_node_z;
                    if (r_nodes < tsma_pkg::MAX_NODES) r_nodes <= r_nodes + 1'b1;
                end
                tsma_pkg::OP_ACC: begin
                    r_dsum <= s_dsum[tsma_pkg::DSUM_W] ? '1 : s_dsum[tsma_pkg::DSUM_W-1:0];
                    r_lsum <= s_lsum[tsma_pkg::TLEN_W] ? '1 : s_lsum[tsma_pkg::TLEN_W-1:0];
                    r_ssum <= s_ssum[tsma_pkg::SUM_W]  ? '1 : s_ssum[tsma_pkg::SUM_W-1:0];
                    r_vsum <= s_vsum[tsma_pkg::SUM_W]  ? '1 : s_vsum[tsma_pkg::SUM_W-1:0];
                    if (r_rdist > r_dmax) r_dmax <= r_rdist;
                end
                tsma_pkg::OP_EMIT: begin
                    // start the next tree
                    r_min_x <= '1;
                    r_min_y <= '1;
                    r_min_z <= '1;
                    r_max_x <= '0;
                    r_max_y <= '0;
                    r_max_z <= '0;
                    r_dsum  <= '0;
                    r_lsum  <= '0;
                    r_ssum  <= '0;
                    r_vsum  <= '0;
                    r_dmax  <= '0;
                    r_nodes <= '0;
                end
                default: ;
            endcase
        end
    end

    // output register handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == tsma_pkg::OP_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_status.has_parent = r_hp;
    assign o_status.last       = r_last;
    assign o_status.out_free   = !r_out_valid || !i_out_stall;

    `TSMA_ASSERT_IMPL(a_emit_into_free_slot, i_clk, i_rst_n, i_cmd.op == tsma_pkg::OP_EMIT, !r_out_valid || !i_out_stall)
    `TSMA_ASSERT_IMPL(a_valid_from_emit, i_clk, i_rst_n, $rose(r_out_valid), $past(i_cmd.op == tsma_pkg::OP_EMIT))
    `TSMA_ASSERT_NEXT(a_valid_held_on_stall, i_clk, i_rst_n, r_out_valid && i_out_stall, r_out_valid)

endmodule

`default_nettype wire

/* hw/rtl/tree_segment_morphology_accumulator_top.sv */
// Tree morphology accumulator: one node per transfer, one summary per tree.
// A node without a parent passes only the load and dispatch states before the
// next transfer; a node with a parent also runs three squaring steps and the
// square-root unit, producing one result bit per cycle, twice (segment length,
// then root distance), plus seven multiply steps on one shared 32x32
// multiplier and one accumulate step. A last node then runs the 34-step
// restoring divider that forms the average diameter. The summary sits in an
// output register, so the next tree can start while it waits. Depends on
// tsma_pkg, tsma_ctrl and tsma_dpath.
`timescale 1ns / 1ps
`default_nettype none

module tree_segment_morphology_accumulator_top (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [tsma_pkg::CFG_W-1:0]           i_cfg_addr,
    input  wire logic [tsma_pkg::COORD_W-1:0]         i_cfg_data,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire logic [tsma_pkg::COORD_W-1:0]         i_node_x,
    input  wire logic [tsma_pkg::COORD_W-1:0]         i_node_y,
    input  wire logic [tsma_pkg::COORD_W-1:0]         i_node_z,
    input  wire logic [tsma_pkg::RAD_W-1:0]           i_node_radius,
    input  wire logic                                 i_has_parent,
    input  wire logic [tsma_pkg::COORD_W-1:0]         i_parent_x,
    input  wire logic [tsma_pkg::COORD_W-1:0]         i_parent_y,
    input  wire logic [tsma_pkg::COORD_W-1:0]         i_parent_z,
    input  wire logic                                 i_last_node,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output logic [tsma_pkg::COORD_W-1:0]              o_width,
    output logic [tsma_pkg::COORD_W-1:0]              o_height,
    output logic [tsma_pkg::COORD_W-1:0]              o_depth_extent,
    output logic [tsma_pkg::DIAM_W-1:0]               o_average_diameter,
    output logic [tsma_pkg::TLEN_W-1:0]               o_total_length,
    output logic [tsma_pkg::SUM_W-1:0]                o_total_surface,
    output logic [tsma_pkg::SUM_W-1:0]                o_total_volume,
    output logic [tsma_pkg::SEG_W-1:0]                o_max_root_distance,
    output logic [tsma_pkg::NODES_W-1:0]              o_node_count
);

    tsma_pkg::t_cmd    s_cmd;
    tsma_pkg::t_status s_status;

    tsma_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (s_status),
        .o_cmd      (s_cmd)
    );

    tsma_dpath u_dpath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_addr          (i_cfg_addr),
        .i_cfg_data          (i_cfg_data),
        .i_node_x            (i_node_x),
        .i_node_y            (i_node_y),
        .i_node_z            (i_node_z),
        .i_node_radius       (i_node_radius),
        .i_has_parent        (i_has_parent),
        .i_parent_x          (i_parent_x),
        .i_parent_y          (i_parent_y),
        .i_parent_z          (i_parent_z),
        .i_last_node         (i_last_node),
        .i_cmd               (s_cmd),
        .o_status            (s_status),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_width             (o_width),
        .o_height            (o_height),
        .o_depth_extent      (o_depth_extent),
        .o_average_diameter  (o_average_diameter),
        .o_total_length      (o_total_length),
        .o_total_surface     (o_total_surface),
        .o_total_volume      (o_total_volume),
        .o_max_root_distance (o_max_root_distance),
        .o_node_count        (o_node_count)
    );

endmodule

`default_nettype wire
